// ----- hw/rtl/depq_pkg.sv -----
package depq_pkg;

    // queue geometry and field widths
    localparam int CAPACITY    = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int PRIO_WIDTH  = 8;
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
    localparam int ADDR_WIDTH  = $clog2(CAPACITY);

    // request codes
    typedef enum logic [1:0] {
        REQ_ENQ   = 2'd0,
        REQ_RMMAX = 2'd1,
        REQ_RMMIN = 2'd2,
        REQ_FIND  = 2'd3
    } t_req;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ_RD,
        S_ENQ_CMP,
        S_SHF_RD,
        S_SHF_WR,
        S_FND_RD,
        S_FND_CMP,
        S_OUT_F,
        S_OUT_R,
        S_OUT_W
    } t_state;

    // one stored entry
    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic [PRIO_WIDTH-1:0] rank;
    } t_entry;

    // input item
    typedef struct packed {
        logic [1:0]            req_type;
        logic [DATA_WIDTH-1:0] item_data;
        logic [PRIO_WIDTH-1:0] item_priority;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0]             status;
        logic [DATA_WIDTH-1:0]  front_data;
        logic [DATA_WIDTH-1:0]  rear_data;
        logic [COUNT_WIDTH-1:0] entry_count;
        logic [PRIO_WIDTH-1:0]  found_priority;
        logic [COUNT_WIDTH-1:0] match_count;
    } t_out_item;

endpackage

// ----- hw/rtl/double_ended_priority_queue_core.sv -----
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+----------------------------
// in      | input     | i_in_valid / o_in_stall   | i_in  (depq_pkg::t_in_item)
// out     | output    | o_out_valid / i_out_stall | o_out (depq_pkg::t_out_item)
//
// one request at a time through an entry RAM with one write port and one
// registered read port and one shared compare; each visited entry takes a
// read step and then a compare or write step
// enqueue moves lower-ranked entries back one slot from the rear; remove max
// moves every entry forward; remove min only drops the rear; find visits
// every entry held; full and empty cases go straight to the result steps
// reset clears the entry count and control only, the RAM keeps its contents
// a stalled result holds o_out; the next request may be taken meanwhile and
// waits in its last step until the output register is free
module double_ended_priority_queue_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  depq_pkg::t_in_item i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output depq_pkg::t_out_item o_out
);

    localparam int CW = depq_pkg::COUNT_WIDTH;
    localparam int AW = depq_pkg::ADDR_WIDTH;

    depq_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_match, n_match;
    logic [depq_pkg::PRIO_WIDTH-1:0] r_found, n_found;
    depq_pkg::t_status   r_status, n_status;
    logic [depq_pkg::DATA_WIDTH-1:0] r_front, n_front;
    depq_pkg::t_in_item  r_item, n_item;
    logic                r_out_valid, n_out_valid;
    depq_pkg::t_out_item r_out, n_out;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    depq_pkg::t_entry    wr_data;
    logic [AW-1:0]       rd_addr;
    depq_pkg::t_entry    rd_data;
    logic [CW-1:0]       idx_dec;
    logic [CW-1:0]       count_dec;
    depq_pkg::t_entry    new_entry;

    assign idx_dec   = r_idx - 1'b1;
    assign count_dec = r_count - 1'b1;
    assign new_entry = '{value: r_item.item_data, rank: r_item.item_priority};

    // entry storage
    depq_ram #(
        .WIDTH ($bits(depq_pkg::t_entry)),
        .DEPTH (depq_pkg::CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= depq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_match  <= n_match;
        r_found  <= n_found;
        r_status <= n_status;
        r_front  <= n_front;
        r_item   <= n_item;
        r_out    <= n_out;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_match     = r_match;
        n_found     = r_found;
        n_status    = r_status;
        n_front     = r_front;
        n_item      = r_item;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        wr_en       = 1'b0;
        wr_addr     = r_idx[AW-1:0];
        wr_data     = rd_data;
        rd_addr     = r_idx[AW-1:0];

        // result transfer frees the output register
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            depq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_item   = i_in;
                    n_status = depq_pkg::ST_OK;
                    n_match  = '0;
                    n_found  = '0;
                    unique case (depq_pkg::t_req'(i_in.req_type))
                        depq_pkg::REQ_ENQ: begin
                            n_idx = r_count;
                            if (r_count >= CW'(depq_pkg::CAPACITY)) begin
                                n_status = depq_pkg::ST_FULL;
                                n_state  = depq_pkg::S_OUT_F;
                            end else begin
                                n_state = depq_pkg::S_ENQ_RD;
                            end
                        end
                        depq_pkg::REQ_RMMAX: begin
                            n_idx = CW'(1);
                            if (r_count == '0) begin
                                n_status = depq_pkg::ST_EMPTY;
                                n_state  = depq_pkg::S_OUT_F;
                            end else begin
                                n_state = depq_pkg::S_SHF_RD;
                            end
                        end
                        depq_pkg::REQ_RMMIN: begin
                            if (r_count == '0) begin
                                n_status = depq_pkg::ST_EMPTY;
                            end else begin
                                n_count = count_dec;
                            end
                            n_state = depq_pkg::S_OUT_F;
                        end
                        depq_pkg::REQ_FIND: begin
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_status = depq_pkg::ST_EMPTY;
                                n_state  = depq_pkg::S_OUT_F;
                            end else begin
                                n_state = depq_pkg::S_FND_RD;
                            end
                        end
                    endcase
                end
            end

            // enqueue: walk from the rear, moving lower ranks back one slot
            depq_pkg::S_ENQ_RD: begin
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = new_entry;
                    n_count = r_count + 1'b1;
                    n_state = depq_pkg::S_OUT_F;
                end else begin
                    rd_addr = idx_dec[AW-1:0];
                    n_state = depq_pkg::S_ENQ_CMP;
                end
            end
            depq_pkg::S_ENQ_CMP: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[AW-1:0];
                if (rd_data.rank < r_item.item_priority) begin
                    wr_data = rd_data;
                    n_idx   = idx_dec;
                    n_state = depq_pkg::S_ENQ_RD;
                end else begin
                    wr_data = new_entry;
                    n_count = r_count + 1'b1;
                    n_state = depq_pkg::S_OUT_F;
                end
            end

            // remove max: move every entry one slot forward
            depq_pkg::S_SHF_RD: begin
                if (r_idx >= r_count) begin
                    n_count = count_dec;
                    n_state = depq_pkg::S_OUT_F;
                end else begin
                    n_state = depq_pkg::S_SHF_WR;
                end
            end
            depq_pkg::S_SHF_WR: begin
                wr_en   = 1'b1;
                wr_addr = idx_dec[AW-1:0];
                wr_data = rd_data;
                n_idx   = r_idx + 1'b1;
                n_state = depq_pkg::S_SHF_RD;
            end

            // find: scan from the front, count matches
            depq_pkg::S_FND_RD: begin
                if (r_idx == r_count) begin
                    if (r_match == '0) begin
                        n_status = depq_pkg::ST_NOTFOUND;
                    end
                    n_state = depq_pkg::S_OUT_F;
                end else begin
                    n_state = depq_pkg::S_FND_CMP;
                end
            end
            depq_pkg::S_FND_CMP: begin
                if (rd_data.value == r_item.item_data) begin
                    if (r_match == '0) begin
                        n_found = rd_data.rank;
                    end
                    n_match = r_match + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = depq_pkg::S_FND_RD;
            end

            // fetch front and rear entries
            depq_pkg::S_OUT_F: begin
                rd_addr = '0;
                n_state = depq_pkg::S_OUT_R;
            end
            depq_pkg::S_OUT_R: begin
                n_front = rd_data.value;
                rd_addr = count_dec[AW-1:0];
                n_state = depq_pkg::S_OUT_W;
            end

            // load the result once the output register is free, keeping the
            // rear entry on the read port while waiting
            depq_pkg::S_OUT_W: begin
                rd_addr = count_dec[AW-1:0];
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status         = r_status;
                    n_out.front_data     = (r_count == '0) ? '0 : r_front;
                    n_out.rear_data      = (r_count == '0) ? '0 : rd_data.value;
                    n_out.entry_count    = r_count;
                    n_out.found_priority = r_found;
                    n_out.match_count    = r_match;
                    n_out_valid          = 1'b1;
                    n_state              = depq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = depq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != depq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // held count stays within capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(depq_pkg::CAPACITY))
        else $error("entry count above capacity");

    // an empty queue reports zero front and rear data
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.entry_count == '0) |->
            (o_out.front_data == '0) && (o_out.rear_data == '0))
        else $error("empty queue shows data");

    // matches are reported only with ok status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.match_count != '0) |->
            (o_out.status == depq_pkg::ST_OK))
        else $error("match count with non-ok status");

    // an accepted request keeps the input side busy next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not held off after transfer");

    // a find result never reports more matches than entries held
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.match_count <= o_out.entry_count))
        else $error("match count above entry count");

endmodule

// ----- hw/rtl/depq_ram.sv -----
module depq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 60;
    localparam int DW           = depq_pkg::DATA_WIDTH;
    localparam int PW           = depq_pkg::PRIO_WIDTH;
    localparam int CW           = depq_pkg::COUNT_WIDTH;

    // clock, reset and channel signals
    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_stall;
    depq_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_stall;
    depq_pkg::t_out_item out_item;

    double_ended_priority_queue_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the sorted queue, slot 0 is the front
    logic [DW-1:0] shadow_value [depq_pkg::CAPACITY];
    logic [PW-1:0] shadow_rank  [depq_pkg::CAPACITY];
    int            shadow_held;

    // results still owed by the block, oldest first
    depq_pkg::t_out_item awaited_views [$];

    int error_count;
    int sent_count;
    int checked_count;
    int cycle_count;
    int full_rejects;
    int empty_hits;
    int find_misses;
    int find_hits;
    int peak_depth;
    bit idle_en;
    int stall_left;

    // directed stimulus table
    typedef struct {
        depq_pkg::t_req      req;
        logic [DW-1:0]       data;
        logic [PW-1:0]       prio;
        int                  reps;
        bit                  typed;
        depq_pkg::t_out_item want;
    } t_row;

    t_row          rows [$];
    logic [DW-1:0] data_pool [8];

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic depq_pkg::t_out_item queue_view(input depq_pkg::t_status st,
                                                       input logic [DW-1:0] front,
                                                       input logic [DW-1:0] rear,
                                                       input int count, input int prio,
                                                       input int hit_total);
        depq_pkg::t_out_item v;
        v.status         = st;
        v.front_data     = front;
        v.rear_data      = rear;
        v.entry_count    = CW'(count);
        v.found_priority = PW'(prio);
        v.match_count    = CW'(hit_total);
        return v;
    endfunction

    // apply one request to the shadow queue and return the view after it
    function automatic depq_pkg::t_out_item next_queue_view(input depq_pkg::t_in_item r);
        depq_pkg::t_out_item v;
        int                  slot;
        int                  hit_total;
        v         = '0;
        v.status  = depq_pkg::ST_OK;
        hit_total = 0;
        case (depq_pkg::t_req'(r.req_type))
            depq_pkg::REQ_ENQ: begin
                if (shadow_held >= depq_pkg::CAPACITY) begin
                    v.status = depq_pkg::ST_FULL;
                end else begin
                    // new entry goes behind every entry of equal or higher rank
                    slot = 0;
                    while (slot < shadow_held && shadow_rank[slot] >= r.item_priority)
                        slot++;
                    for (int i = shadow_held; i > slot; i--) begin
                        shadow_value[i] = shadow_value[i-1];
                        shadow_rank[i]  = shadow_rank[i-1];
                    end
                    shadow_value[slot] = r.item_data;
                    shadow_rank[slot]  = r.item_priority;
                    shadow_held++;
                end
            end
            depq_pkg::REQ_RMMAX: begin
                if (shadow_held == 0) begin
                    v.status = depq_pkg::ST_EMPTY;
                end else begin
                    for (int i = 1; i < shadow_held; i++) begin
                        shadow_value[i-1] = shadow_value[i];
                        shadow_rank[i-1]  = shadow_rank[i];
                    end
                    shadow_held--;
                end
            end
            depq_pkg::REQ_RMMIN: begin
                if (shadow_held == 0) v.status = depq_pkg::ST_EMPTY;
                else shadow_held--;
            end
            default: begin
                if (shadow_held == 0) begin
                    v.status = depq_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < shadow_held; i++) begin
                        if (shadow_value[i] == r.item_data) begin
                            if (hit_total == 0) v.found_priority = shadow_rank[i];
                            hit_total++;
                        end
                    end
                    if (hit_total == 0) v.status = depq_pkg::ST_NOTFOUND;
                    else find_hits++;
                end
            end
        endcase
        v.front_data  = (shadow_held > 0) ? shadow_value[0] : '0;
        v.rear_data   = (shadow_held > 0) ? shadow_value[shadow_held-1] : '0;
        v.entry_count = CW'(shadow_held);
        v.match_count = CW'(hit_total);
        // coverage tallies for the summary
        case (depq_pkg::t_status'(v.status))
            depq_pkg::ST_FULL:     full_rejects++;
            depq_pkg::ST_EMPTY:    empty_hits++;
            depq_pkg::ST_NOTFOUND: find_misses++;
            default: ;
        endcase
        if (shadow_held > peak_depth) peak_depth = shadow_held;
        return v;
    endfunction

    // one input transfer, optionally after a short idle burst
    task automatic send_request(input depq_pkg::t_in_item r, input bit typed,
                                input depq_pkg::t_out_item want);
        depq_pkg::t_out_item model_view;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= r;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        model_view = next_queue_view(r);
        awaited_views.push_back(typed ? want : model_view);
        sent_count++;
        @(negedge i_clk);
    endtask

    function automatic depq_pkg::t_in_item pick_request(input bit filling);
        depq_pkg::t_in_item r;
        int                 roll;
        roll            = $urandom_range(0, 99);
        r.item_data     = ($urandom_range(0, 1) == 0) ? data_pool[$urandom_range(0, 7)]
                                                      : $urandom;
        r.item_priority = ($urandom_range(0, 2) == 0) ? PW'($urandom_range(0, 3))
                                                      : PW'($urandom);
        // fill phases lean on enqueue, drain phases on removal
        if (filling) begin
            if (roll < 60)      r.req_type = depq_pkg::REQ_ENQ;
            else if (roll < 75) r.req_type = depq_pkg::REQ_FIND;
            else if (roll < 88) r.req_type = depq_pkg::REQ_RMMAX;
            else                r.req_type = depq_pkg::REQ_RMMIN;
        end else begin
            if (roll < 25)      r.req_type = depq_pkg::REQ_ENQ;
            else if (roll < 45) r.req_type = depq_pkg::REQ_FIND;
            else if (roll < 72) r.req_type = depq_pkg::REQ_RMMAX;
            else                r.req_type = depq_pkg::REQ_RMMIN;
        end
        return r;
    endfunction

    task automatic add_row(input depq_pkg::t_req req, input logic [DW-1:0] data,
                           input logic [PW-1:0] prio, input int reps,
                           input bit typed, input depq_pkg::t_out_item want);
        t_row row;
        row.req   = req;
        row.data  = data;
        row.prio  = prio;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        rows.push_back(row);
    endtask

    // result side stall bursts
    always @(negedge i_clk) begin
        if (!idle_en) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin
        depq_pkg::t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            checked_count++;
            if (awaited_views.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = awaited_views.pop_front();
                if (out_item.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              out_item.status, want.status));
                if (out_item.front_data !== want.front_data)
                    report_mismatch($sformatf("front_data got %h want %h",
                                              out_item.front_data, want.front_data));
                if (out_item.rear_data !== want.rear_data)
                    report_mismatch($sformatf("rear_data got %h want %h",
                                              out_item.rear_data, want.rear_data));
                if (out_item.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              out_item.entry_count, want.entry_count));
                if (out_item.found_priority !== want.found_priority)
                    report_mismatch($sformatf("found_priority got %0d want %0d",
                                              out_item.found_priority,
                                              want.found_priority));
                if (out_item.match_count !== want.match_count)
                    report_mismatch($sformatf("match_count got %0d want %0d",
                                              out_item.match_count, want.match_count));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        depq_pkg::t_in_item r;
        t_row               row;
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        i_rst_n       = 1'b0;
        idle_en       = 1'b1;
        stall_left    = 0;
        error_count   = 0;
        sent_count    = 0;
        checked_count = 0;
        cycle_count   = 0;
        full_rejects  = 0;
        empty_hits    = 0;
        find_misses   = 0;
        find_hits     = 0;
        peak_depth    = 0;
        shadow_held   = 0;

        // small data pool so finds hit and duplicates pile up
        data_pool[0] = '0;
        data_pool[1] = '1;
        for (int i = 2; i < 8; i++) data_pool[i] = $urandom;

        // directed part: empty queue, extremes, ties, full queue, drain
        add_row(depq_pkg::REQ_RMMAX, '0, '0, 1, 1'b1,
                queue_view(depq_pkg::ST_EMPTY, '0, '0, 0, 0, 0));
        add_row(depq_pkg::REQ_RMMIN, '0, '1, 1, 1'b1,
                queue_view(depq_pkg::ST_EMPTY, '0, '0, 0, 0, 0));
        add_row(depq_pkg::REQ_FIND, 32'h1357_9bdf, '0, 1, 1'b1,
                queue_view(depq_pkg::ST_EMPTY, '0, '0, 0, 0, 0));
        add_row(depq_pkg::REQ_ENQ, '1, '1, 1, 1'b1,
                queue_view(depq_pkg::ST_OK, '1, '1, 1, 0, 0));
        add_row(depq_pkg::REQ_ENQ, '0, '0, 1, 1'b1,
                queue_view(depq_pkg::ST_OK, '1, '0, 2, 0, 0));
        add_row(depq_pkg::REQ_FIND, '1, '0, 1, 1'b1,
                queue_view(depq_pkg::ST_OK, '1, '0, 2, 255, 1));
        add_row(depq_pkg::REQ_FIND, 32'h1234_5678, '0, 1, 1'b1,
                queue_view(depq_pkg::ST_NOTFOUND, '1, '0, 2, 0, 0));
        add_row(depq_pkg::REQ_ENQ, 32'ha5a5_a5a5, 8'hff, 1, 1'b0, '0);
        add_row(depq_pkg::REQ_ENQ, 32'h0000_0001, 8'h00, 1, 1'b0, '0);
        add_row(depq_pkg::REQ_RMMIN, '0, '0, 1, 1'b0, '0);
        add_row(depq_pkg::REQ_RMMAX, '0, '0, 1, 1'b0, '0);
        add_row(depq_pkg::REQ_ENQ, 32'h5a5a_5a5a, 8'h80, 13, 1'b0, '0);
        add_row(depq_pkg::REQ_ENQ, 32'h3c3c_3c3c, 8'h01, 1, 1'b0, '0);
        add_row(depq_pkg::REQ_ENQ, 32'h7777_7777, 8'hc8, 1, 1'b1,
                queue_view(depq_pkg::ST_FULL, 32'ha5a5_a5a5, '0, 16, 0, 0));
        add_row(depq_pkg::REQ_FIND, 32'h5a5a_5a5a, '0, 1, 1'b1,
                queue_view(depq_pkg::ST_OK, 32'ha5a5_a5a5, '0, 16, 128, 13));
        add_row(depq_pkg::REQ_FIND, '0, '0, 1, 1'b0, '0);
        add_row(depq_pkg::REQ_RMMAX, '0, '0, 8, 1'b0, '0);
        add_row(depq_pkg::REQ_RMMIN, '0, '0, 8, 1'b0, '0);
        add_row(depq_pkg::REQ_RMMAX, '0, '0, 1, 1'b1,
                queue_view(depq_pkg::ST_EMPTY, '0, '0, 0, 0, 0));
        add_row(depq_pkg::REQ_ENQ, '1, '0, 1, 1'b1,
                queue_view(depq_pkg::ST_OK, '1, '1, 1, 0, 0));
        add_row(depq_pkg::REQ_RMMIN, '0, '0, 1, 1'b1,
                queue_view(depq_pkg::ST_OK, '0, '0, 0, 0, 0));

        // hold synchronous reset, then release it on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) begin
            row = rows[k];
            for (int n = 0; n < row.reps; n++) begin
                r.req_type      = row.req;
                r.item_data     = row.data;
                r.item_priority = row.prio;
                send_request(r, row.typed, row.want);
            end
        end

        // random part: alternating fill and drain phases, a quiet stretch in
        // the middle and no idling at the tail
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_en <= !((n >= 400 && n < 500) || n >= 850);
            r = pick_request(((n / 60) % 2) == 0);
            send_request(r, 1'b0, '0);
        end

        in_valid <= 1'b0;
        while (awaited_views.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d requests sent, %0d results checked, peak depth %0d",
                 sent_count, checked_count, peak_depth);
        $display("tb_top: full rejects %0d, empty requests %0d, finds hit %0d, missed %0d",
                 full_rejects, empty_hits, find_hits, find_misses);
        if (error_count == 0 && awaited_views.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/depq_pkg.sv
hw/rtl/depq_ram.sv
hw/rtl/double_ended_priority_queue_core.sv
tb/tb_top.sv
